// ----- rtl/ilp_pkg.sv -----
// shared types, constants and helper functions for the integer literal parser
// no dependencies; imported by every module of the block
package ilp_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int OUT_W       = 64;
  localparam int CH_W        = 8;
  localparam int EXT_W       = VALUE_WIDTH + 4;
  localparam int DIG_W       = 6;
  localparam int BASE_W      = 5;

  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_LOW_B  = 8'h62;
  localparam logic [CH_W-1:0] CH_LOW_X  = 8'h78;
  localparam logic [CH_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;

  localparam logic [DIG_W-1:0] DIGIT_NONE = 6'd36;

  typedef enum logic [2:0] {
    PH_START,
    PH_AFTER_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RC_DEC,
    RC_BIN,
    RC_OCT,
    RC_HEX
  } radix_t;

  typedef struct packed {
    logic                   is_digit;
    logic                   ovf;
    logic [VALUE_WIDTH-1:0] acc;
  } digit_res_t;

  typedef struct packed {
    logic                   ok;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } parse_res_t;

  function automatic logic [DIG_W-1:0] digit_val(input logic [CH_W-1:0] c);
    logic [DIG_W-1:0] d;
    d = DIGIT_NONE;
    if (c inside {[8'h30:8'h39]}) begin
      d = DIG_W'(c - CH_ZERO);
    end else if (c inside {[8'h61:8'h7a]}) begin
      d = DIG_W'(c - CH_LOW_A) + DIG_W'(10);
    end else if (c inside {[8'h41:8'h5a]}) begin
      d = DIG_W'(c - CH_UP_A) + DIG_W'(10);
    end
    return d;
  endfunction

  function automatic logic [BASE_W-1:0] radix_base(input radix_t rc);
    logic [BASE_W-1:0] b;
    case (rc)
      RC_DEC:  b = 5'd10;
      RC_BIN:  b = 5'd2;
      RC_OCT:  b = 5'd8;
      RC_HEX:  b = 5'd16;
      default: b = 5'd10;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/integer_literal_parser.sv -----
// top level: input register, parse state, result register
// depends on ilp_pkg and ilp_core
//
//   channel | ports                                      | role
//   --------+--------------------------------------------+---------------------------
//   in      | in_valid in_ready in_ch in_has_char in_last | one byte of the string
//   out     | out_valid out_ready out_valid_res out_value | one result per string
//
// one beat per cycle sustained while no last beat stalls; a result appears once its last
// beat, held in the input register, fires into the result register
// the digit multiply-add and the parse state update sit between the two registers
// a result waiting in the output register stalls only a last beat behind it
// synchronous active-low reset returns the parse state to start of string
module integer_literal_parser
  import ilp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CH_W-1:0]       in_ch,
  input  logic                  in_has_char,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_valid_res,
  output logic signed [OUT_W-1:0] out_value
);

  logic                   s1_valid_r;
  logic [CH_W-1:0]        s1_ch_r;
  logic                   s1_has_r;
  logic                   s1_last_r;
  logic                   s1_fire;
  logic                   out_free;

  logic                   out_valid_r;
  logic                   out_ok_r;
  logic                   out_neg_r;
  logic [VALUE_WIDTH-1:0] out_mag_r;

  parse_res_t                     pres;
  logic signed [VALUE_WIDTH-1:0]  val_w;

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch_r   <= in_ch;
      s1_has_r  <= in_has_char;
      s1_last_r <= in_last;
    end
  end

  ilp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .ch       (s1_ch_r),
    .has_char (s1_has_r),
    .last     (s1_last_r),
    .res      (pres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_ok_r  <= pres.ok;
      out_neg_r <= pres.neg;
      out_mag_r <= pres.mag;
    end
  end

  // sign applied on the registered magnitude, then sign-extended to the port
  assign val_w         = out_neg_r ? signed'(-out_mag_r) : signed'(out_mag_r);
  assign out_valid     = out_valid_r;
  assign out_valid_res = out_ok_r;
  assign out_value     = out_ok_r ? OUT_W'(val_w) : '0;

`ifndef SYNTH
  a_ready_only_blocked_by_last : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a pending last beat");

  a_pending_last_kept : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && !out_free) |=> (s1_valid_r && s1_last_r))
    else $error("last beat dropped while result slot full");

  a_invalid_reads_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_value == '0))
    else $error("invalid result carries a non-zero value");

  a_result_follows_last : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> out_valid)
    else $error("last beat did not produce a result");
`endif

endmodule

// ----- rtl/ilp_digit.sv -----
// one digit step: classify the byte against the base and multiply-add it in
// depends on ilp_pkg
module ilp_digit
  import ilp_pkg::*;
(
  input  logic [CH_W-1:0]        ch,
  input  radix_t                 rc,
  input  logic [VALUE_WIDTH-1:0] acc,
  output digit_res_t             res
);

  logic [DIG_W-1:0] dv;
  logic [EXT_W-1:0] ext;
  logic [EXT_W-1:0] scaled;
  logic [EXT_W-1:0] sum;

  assign dv  = digit_val(ch);
  assign ext = EXT_W'(acc);

  // constant-base multiply as shifts, plus one add for decimal
  always_comb begin
    case (rc)
      RC_DEC:  scaled = (ext << 3) + (ext << 1);
      RC_BIN:  scaled = ext << 1;
      RC_OCT:  scaled = ext << 3;
      RC_HEX:  scaled = ext << 4;
      default: scaled = ext;
    endcase
  end

  assign sum = scaled + EXT_W'(dv);

  assign res.is_digit = (dv < DIG_W'(radix_base(rc)));
  assign res.ovf      = |sum[EXT_W-1:VALUE_WIDTH];
  assign res.acc      = sum[VALUE_WIDTH-1:0];

endmodule

// ----- rtl/ilp_core.sv -----
// parse state: phase, sign, radix, accumulator, overflow and digit-seen flag, one beat per cycle while fire is high
// depends on ilp_pkg and ilp_digit
module ilp_core
  import ilp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [CH_W-1:0] ch,
  input  logic            has_char,
  input  logic            last,
  output parse_res_t      res
);

  phase_t                 phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  radix_t                 radix_r, radix_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   seen_r, seen_nxt;

  radix_t     rc_eff;
  digit_res_t dg;
  logic       is_minus;
  logic       is_zero;
  logic       is_prefix;
  logic       take;

  assign is_minus  = (ch == CH_MINUS);
  assign is_zero   = (ch == CH_ZERO);
  assign is_prefix = (ch == CH_LOW_B) || (ch == CH_LOW_X);
  assign rc_eff    = ((phase_r == PH_START) || (phase_r == PH_AFTER_SIGN)) ? RC_DEC : radix_r;

  ilp_digit u_digit (
    .ch  (ch),
    .rc  (rc_eff),
    .acc (acc_r),
    .res (dg)
  );

  // whether this beat goes through the digit step
  always_comb begin
    take = 1'b0;
    if (has_char) begin
      case (phase_r)
        PH_START:      take = !is_minus && !is_zero;
        PH_AFTER_SIGN: take = !is_zero;
        PH_ZERO:       take = !is_prefix;
        PH_DIGITS:     take = 1'b1;
        default:       take = 1'b0;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (has_char) begin
      case (phase_r)
        PH_START: begin
          if (is_minus) begin
            phase_nxt = PH_AFTER_SIGN;
          end else if (is_zero) begin
            phase_nxt = PH_ZERO;
          end else begin
            phase_nxt = dg.is_digit ? PH_DIGITS : PH_DONE;
          end
        end
        PH_AFTER_SIGN: begin
          if (is_zero) begin
            phase_nxt = PH_ZERO;
          end else begin
            phase_nxt = dg.is_digit ? PH_DIGITS : PH_DONE;
          end
        end
        PH_ZERO: begin
          if (is_prefix) begin
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = dg.is_digit ? PH_DIGITS : PH_DONE;
          end
        end
        PH_DIGITS: phase_nxt = dg.is_digit ? PH_DIGITS : PH_DONE;
        default:   phase_nxt = phase_r;
      endcase
    end
  end

  // data updates
  always_comb begin
    neg_nxt   = neg_r;
    radix_nxt = radix_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    seen_nxt  = seen_r;
    if (has_char) begin
      case (phase_r)
        PH_START, PH_AFTER_SIGN: begin
          if ((phase_r == PH_START) && is_minus) begin
            neg_nxt = 1'b1;
          end else if (is_zero) begin
            radix_nxt = RC_OCT;
            acc_nxt   = '0;
            seen_nxt  = 1'b1;
          end else begin
            radix_nxt = RC_DEC;
          end
        end
        PH_ZERO: begin
          if (is_prefix) begin
            radix_nxt = (ch == CH_LOW_B) ? RC_BIN : RC_HEX;
            seen_nxt  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (take && dg.is_digit) begin
      seen_nxt = 1'b1;
      if (!ovf_r) begin
        if (dg.ovf) begin
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = dg.acc;
        end
      end
    end
  end

  assign res.ok  = seen_nxt && !ovf_nxt;
  assign res.neg = neg_nxt;
  assign res.mag = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      radix_r <= RC_DEC;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      seen_r  <= 1'b0;
    end else if (fire) begin
      if (last) begin
        phase_r <= PH_START;
        neg_r   <= 1'b0;
        radix_r <= RC_DEC;
        acc_r   <= '0;
        ovf_r   <= 1'b0;
        seen_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        radix_r <= radix_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

endmodule
